// ===== sv/mse_pkg.sv =====
// Package for the MIPS subset execute block: opcodes, funct codes, controller
// states and the command/status structs between controller and datapath.
// No dependencies.
package mse_pkg;

  localparam int unsigned DATA_WORDS_DEF = 256;
  localparam int unsigned NREGS = 32;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_BGTZ  = 6'h07;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_SLTI  = 6'h0a;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_XORI  = 6'h0e;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2b;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_SYS  = 6'h0c;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_DIV  = 6'h1a;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2a;

  localparam logic [31:0] SYS_PRINT = 32'd1;
  localparam logic [31:0] SYS_EXIT  = 32'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_MEM,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture instruction
    logic read_regs; // latch rs/rt operands
    logic exec;      // compute and commit
    logic div_start;
    logic div_step;
    logic mem_wb;    // write load data back
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic halted;
    logic is_div;
    logic is_load;
    logic div_last;
  } dp_stat_t;

endpackage

// ===== sv/mse_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module mse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== sv/mse_ctrl.sv =====
// Controller state machine: sequences read, execute, divide and memory steps.
// Depends on mse_pkg.
module mse_ctrl
  import mse_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read_regs = 1'b1;
        if (stat.halted) begin
          state_nxt = ST_EXEC;
        end else if (stat.is_div) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_EXEC;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = (stat.is_load && !stat.halted) ? ST_MEM : ST_DONE;
      end
      ST_MEM: begin
        cmd.mem_wb = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    cmd.div_start = (state_r == ST_READ) && stat.is_div && !stat.halted;
  end

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && stat.div_last) |=> state_r == ST_EXEC)
    else $error("divide did not end in execute");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("request taken while busy");
endmodule

// ===== sv/mse_dpath.sv =====
// Datapath: register file, ALU, serial divider, PC and data memory port.
// Depends on mse_pkg and mse_ram.
module mse_dpath
  import mse_pkg::*;
#(
  parameter int unsigned DATA_WORDS = DATA_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        in_instr_word,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic [15:0]        next_pc,
  output logic               print_valid,
  output logic signed [31:0] print_value,
  output logic               halt,
  output logic               invalid_op,
  output logic               mem_fault
);
  localparam int unsigned AW = $clog2(DATA_WORDS);

  logic [31:0] ir_r;
  logic [31:0] regs_r [NREGS];
  logic [31:0] a_r, b_r, v0_r, a0_r;
  logic [15:0] pc_r;
  logic        halted_r;
  logic [4:0]  ld_rt_r;

  // divider
  logic [31:0] quo_r, rem_r;
  logic [4:0]  dcnt_r;
  logic [32:0] rem_sh;

  logic [15:0] npc_r;
  logic pv_r, hl_r, inv_r, mf_r;
  logic [31:0] pval_r;

  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [31:0] simm, zimm, addr;
  logic [15:0] pc1, br_tgt;
  logic        mem_ok, mem_we;
  logic [31:0] mem_rdata;

  assign op = ir_r[31:26];
  assign rs = ir_r[25:21];
  assign rt = ir_r[20:16];
  assign rd = ir_r[15:11];
  assign sh = ir_r[10:6];
  assign fn = ir_r[5:0];
  assign simm = {{16{ir_r[15]}}, ir_r[15:0]};
  assign zimm = {16'd0, ir_r[15:0]};
  assign pc1 = pc_r + 16'd1;
  assign br_tgt = pc1 + ir_r[15:0];
  assign addr = a_r + simm;
  assign mem_ok = (addr < 32'(DATA_WORDS));

  assign stat.halted = halted_r;
  assign stat.is_div = (op == OP_RTYPE) && (fn == FN_DIV);
  assign stat.is_load = (op == OP_LW) && mem_ok;
  assign stat.div_last = (dcnt_r == 5'd31);

  assign rem_sh = {rem_r, quo_r[31]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ir_r <= in_instr_word;
    end
    if (cmd.read_regs) begin
      a_r <= regs_r[rs];
      b_r <= regs_r[rt];
      v0_r <= regs_r[2];
      a0_r <= regs_r[4];
      ld_rt_r <= rt;
    end
    if (cmd.div_start) begin
      quo_r <= regs_r[rs];
      rem_r <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      // one restoring step per cycle
      if (rem_sh >= {1'b0, b_r}) begin
        rem_r <= 32'(rem_sh - {1'b0, b_r});
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 5'd1;
    end
  end

  // execute
  logic [31:0] res;
  logic [4:0]  wdst;
  logic        wen;
  logic [15:0] npc;
  logic        pv, hl, inv, mf;
  logic [31:0] prod_r;

  always_ff @(posedge clk) begin
    if (cmd.read_regs) begin
      prod_r <= regs_r[rs] * regs_r[rt];
    end
  end

  always_comb begin
    res = '0;
    wdst = rd;
    wen = 1'b0;
    npc = pc1;
    pv = 1'b0;
    hl = 1'b0;
    inv = 1'b0;
    mf = 1'b0;
    mem_we = 1'b0;
    unique case (op)
      OP_RTYPE: begin
        wen = 1'b1;
        unique case (fn)
          FN_ADD:  res = a_r + b_r;
          FN_SUB:  res = a_r - b_r;
          FN_MULT: res = prod_r;
          FN_DIV:  res = (b_r == 32'd0) ? '1 : quo_r;
          FN_AND:  res = a_r & b_r;
          FN_OR:   res = a_r | b_r;
          FN_XOR:  res = a_r ^ b_r;
          FN_NOR:  res = ~(a_r | b_r);
          FN_SLT:  res = {31'd0, $signed(a_r) < $signed(b_r)};
          FN_SLL:  res = b_r << sh;
          FN_SRL:  res = b_r >> sh;
          FN_SRA:  res = 32'($signed(b_r) >>> sh);
          FN_JR: begin
            wen = 1'b0;
            npc = a_r[15:0];
          end
          FN_SYS: begin
            wen = 1'b0;
            if (v0_r == SYS_PRINT) begin
              pv = 1'b1;
            end else if (v0_r == SYS_EXIT) begin
              hl = 1'b1;
            end
          end
          default: begin
            wen = 1'b0;
            inv = 1'b1;
          end
        endcase
      end
      OP_J:   npc = ir_r[15:0];
      OP_JAL: begin
        npc = ir_r[15:0];
        wen = 1'b1;
        wdst = 5'd31;
        res = {16'd0, pc1};
      end
      OP_BEQ:  if (a_r == b_r) npc = br_tgt;
      OP_BNE:  if (a_r != b_r) npc = br_tgt;
      OP_BGTZ: if ($signed(a_r) > 0) npc = br_tgt;
      OP_ADDI: begin wen = 1'b1; wdst = rt; res = a_r + simm; end
      OP_SLTI: begin
        wen = 1'b1;
        wdst = rt;
        res = {31'd0, $signed(a_r) < $signed(simm)};
      end
      OP_ANDI: begin wen = 1'b1; wdst = rt; res = a_r & zimm; end
      OP_ORI:  begin wen = 1'b1; wdst = rt; res = a_r | zimm; end
      OP_XORI: begin wen = 1'b1; wdst = rt; res = a_r ^ zimm; end
      OP_LW: mf = !mem_ok;
      OP_SW: begin
        mf = !mem_ok;
        mem_we = mem_ok;
      end
      default: inv = 1'b1;
    endcase
    mem_we = mem_we && cmd.exec && !halted_r;
  end

  mse_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .addr (addr[AW-1:0]),
    .wdata(b_r),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREGS; i++) begin
        regs_r[i] <= '0;
      end
      pc_r <= '0;
      halted_r <= 1'b0;
    end else begin
      if (cmd.exec && !halted_r) begin
        if (wen && wdst != 5'd0) begin
          regs_r[wdst] <= res;
        end
        pc_r <= npc;
        if (hl) begin
          halted_r <= 1'b1;
        end
      end
      if (cmd.mem_wb && ld_rt_r != 5'd0) begin
        regs_r[ld_rt_r] <= mem_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (halted_r) begin
        npc_r <= pc_r;
        pv_r <= 1'b0; pval_r <= '0; hl_r <= 1'b1; inv_r <= 1'b0; mf_r <= 1'b0;
      end else begin
        npc_r <= npc;
        pv_r <= pv; pval_r <= pv ? a0_r : '0; hl_r <= hl; inv_r <= inv; mf_r <= mf;
      end
    end
  end

  assign next_pc = npc_r;
  assign print_valid = pv_r;
  assign print_value = pval_r;
  assign halt = hl_r;
  assign invalid_op = inv_r;
  assign mem_fault = mf_r;

  a_r0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    regs_r[0] == 32'd0) else $error("r0 changed");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r) else $error("halt cleared");
  a_pc_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> $stable(pc_r)) else $error("pc moved while halted");
  a_halted_out: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && halted_r) |=> (hl_r && !pv_r && !inv_r && !mf_r))
    else $error("halted output wrong");
endmodule

// ===== sv/mips_subset_execute_top.sv =====
// MIPS subset execute block: one instruction word per request, one result
// per request. After acceptance the request passes the read and execute
// states, the divide state for DIV (a 32-step restoring divider) unless halted,
// and the memory state for LW with a legal address unless halted; the result is
// then offered in the done state. The next request is taken in the cycle after
// the result is delivered, so no new request is taken before then.
// Depends on mse_pkg, mse_ctrl, mse_dpath and mse_ram.
module mips_subset_execute_top
  import mse_pkg::*;
#(
  parameter int unsigned DATA_WORDS = DATA_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_instr_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_next_pc,
  output logic               out_print_valid,
  output logic signed [31:0] out_print_value,
  output logic               out_halt,
  output logic               out_invalid_op,
  output logic               out_mem_fault
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  mse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mse_dpath #(.DATA_WORDS(DATA_WORDS)) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_instr_word(in_instr_word),
    .cmd          (cmd),
    .stat         (stat),
    .next_pc      (out_next_pc),
    .print_valid  (out_print_valid),
    .print_value  (out_print_value),
    .halt         (out_halt),
    .invalid_op   (out_invalid_op),
    .mem_fault    (out_mem_fault)
  );
endmodule

// ===== test/mips_subset_execute_chk.sv =====
// Checker for mips_subset_execute_top: watches both channels, keeps its own
// copy of register file, data memory, PC and halt state, and compares every
// result against the predicted one. Depends on mse_pkg.
module mips_subset_execute_chk
  import mse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_instr_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_next_pc,
  input  logic        out_print_valid,
  input  logic [31:0] out_print_value,
  input  logic        out_halt,
  input  logic        out_invalid_op,
  input  logic        out_mem_fault,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic [15:0] next_pc;
    logic        print_valid;
    logic [31:0] print_value;
    logic        halt;
    logic        invalid_op;
    logic        mem_fault;
  } step_res_t;

  logic [31:0] gpr [NREGS];
  logic [31:0] dmem [DATA_WORDS_DEF];
  logic [15:0] pc;
  logic        stopped;
  step_res_t   pending_results[$];

  initial begin
    fails = 0;
    pending = 0;
    pc = '0;
    stopped = 1'b0;
    for (int i = 0; i < NREGS; i++) gpr[i] = '0;
  end

  task automatic put_reg(input logic [4:0] idx, input logic [31:0] val);
    if (idx != 5'd0) gpr[idx] = val;
  endtask

  task automatic execute_instr(input logic [31:0] w, output step_res_t r);
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] a, b, simm, zimm, addr;
    logic [15:0] pc1, branch_pc;
    op = w[31:26]; fn = w[5:0];
    rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sh = w[10:6];
    a = gpr[rs]; b = gpr[rt];
    simm = {{16{w[15]}}, w[15:0]};
    zimm = {16'h0, w[15:0]};
    pc1 = pc + 16'd1;
    branch_pc = pc1 + w[15:0];
    r = '0;
    r.next_pc = pc1;
    if (stopped) begin
      r.next_pc = pc;
      r.halt = 1'b1;
      return;
    end
    case (op)
      OP_RTYPE: begin
        case (fn)
          FN_ADD:  put_reg(rd, a + b);
          FN_SUB:  put_reg(rd, a - b);
          FN_MULT: put_reg(rd, a * b);
          FN_DIV:  put_reg(rd, (b == 0) ? 32'hFFFF_FFFF : a / b);
          FN_AND:  put_reg(rd, a & b);
          FN_OR:   put_reg(rd, a | b);
          FN_XOR:  put_reg(rd, a ^ b);
          FN_NOR:  put_reg(rd, ~(a | b));
          FN_SLT:  put_reg(rd, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
          FN_SLL:  put_reg(rd, b << sh);
          FN_SRL:  put_reg(rd, b >> sh);
          FN_SRA:  put_reg(rd, $unsigned($signed(b) >>> sh));
          FN_JR:   r.next_pc = a[15:0];
          FN_SYS: begin
            if (gpr[2] == SYS_PRINT) begin
              r.print_valid = 1'b1;
              r.print_value = gpr[4];
            end else if (gpr[2] == SYS_EXIT) begin
              r.halt = 1'b1;
              stopped = 1'b1;
            end
          end
          default: r.invalid_op = 1'b1;
        endcase
      end
      OP_J:    r.next_pc = w[15:0];
      OP_JAL: begin
        put_reg(5'd31, {16'h0, pc1});
        r.next_pc = w[15:0];
      end
      OP_BEQ:  if (a == b) r.next_pc = branch_pc;
      OP_BNE:  if (a != b) r.next_pc = branch_pc;
      OP_BGTZ: if ($signed(a) > 0) r.next_pc = branch_pc;
      OP_ADDI: put_reg(rt, a + simm);
      OP_SLTI: put_reg(rt, ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0);
      OP_ANDI: put_reg(rt, a & zimm);
      OP_ORI:  put_reg(rt, a | zimm);
      OP_XORI: put_reg(rt, a ^ zimm);
      OP_LW, OP_SW: begin
        addr = a + simm;
        if (addr >= DATA_WORDS_DEF) r.mem_fault = 1'b1;
        else if (op == OP_LW) put_reg(rt, dmem[addr[7:0]]);
        else dmem[addr[7:0]] = b;
      end
      default: r.invalid_op = 1'b1;
    endcase
    pc = r.next_pc;
  endtask

  always @(posedge clk) begin
    step_res_t pred, got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        execute_instr(in_instr_word, pred);
        pending_results.push_back(pred);
      end
      if (out_valid && out_ready) begin
        got = '{out_next_pc, out_print_valid, out_print_value, out_halt,
                out_invalid_op, out_mem_fault};
        if (pending_results.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, actual %h", $time, got);
        end else begin
          pred = pending_results.pop_front();
          if (got.next_pc != pred.next_pc) begin
            fails++;
            $display("%0t: next_pc expected %h actual %h", $time, pred.next_pc, got.next_pc);
          end
          if (got.print_valid != pred.print_valid) begin
            fails++;
            $display("%0t: print_valid expected %b actual %b", $time,
                     pred.print_valid, got.print_valid);
          end
          if (got.print_value != pred.print_value) begin
            fails++;
            $display("%0t: print_value expected %h actual %h", $time,
                     pred.print_value, got.print_value);
          end
          if (got.halt != pred.halt) begin
            fails++;
            $display("%0t: halt expected %b actual %b", $time, pred.halt, got.halt);
          end
          if (got.invalid_op != pred.invalid_op) begin
            fails++;
            $display("%0t: invalid_op expected %b actual %b", $time,
                     pred.invalid_op, got.invalid_op);
          end
          if (got.mem_fault != pred.mem_fault) begin
            fails++;
            $display("%0t: mem_fault expected %b actual %b", $time,
                     pred.mem_fault, got.mem_fault);
          end
        end
      end
    end
    pending = pending_results.size();
  end

endmodule

// ===== test/mips_subset_execute_top_tb.sv =====
// Testbench top for mips_subset_execute_top: fills data memory, runs directed
// and random instruction streams with random stalls, and gives the verdict.
// Depends on mse_pkg, the block and mips_subset_execute_chk.
module mips_subset_execute_top_tb;
  import mse_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_instr_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_next_pc;
  logic        out_print_valid;
  logic signed [31:0] out_print_value;
  logic        out_halt;
  logic        out_invalid_op;
  logic        out_mem_fault;
  int          fails;
  int          pending;
  int          cycles = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;

  logic [5:0] rfuncts [14] = '{FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_SYS, FN_MULT, FN_DIV,
                               FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT};
  logic [5:0] iops [10] = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BGTZ, OP_ADDI, OP_SLTI,
                            OP_ANDI, OP_ORI, OP_XORI};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mips_subset_execute_top dut (.*);

  mips_subset_execute_chk chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random ready stretches, one long hold on request.
  initial begin
    int len;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (no_idle) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) < 65);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (len) @(posedge clk);
      end
    end
  end

  // Keep random writes away from $v0 so the syscall code stays controlled.
  function automatic logic [31:0] keep_v0(input logic [31:0] w);
    logic [5:0] op;
    op = w[31:26];
    if (op == OP_RTYPE && w[15:11] == 5'd2) w[15:11] = 5'd3;
    if ((op == OP_ADDI || op == OP_SLTI || op == OP_ANDI || op == OP_ORI ||
         op == OP_XORI || op == OP_LW) && w[20:16] == 5'd2) w[20:16] = 5'd3;
    return w;
  endfunction

  // Offer one request; valid stays high into the next one when no gap follows.
  task automatic offer_instr(input logic [31:0] w);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_instr_word <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] rtype(input logic [5:0] fn, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [4:0] rd,
                                        input logic [4:0] sh);
    return {OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_instr();
    int k;
    logic [31:0] w;
    k = $urandom_range(0, 99);
    w = $urandom();
    if (k < 40) begin
      w[31:26] = OP_RTYPE;
      w[5:0] = rfuncts[$urandom_range(0, 13)];
    end else if (k < 70) begin
      w[31:26] = iops[$urandom_range(0, 9)];
    end else if (k < 88) begin
      w[31:26] = $urandom_range(0, 1) ? OP_LW : OP_SW;
      if ($urandom_range(0, 3) != 0) begin
        w[25:21] = 5'd0;
        w[15:0] = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 255));
      end
    end else if (k < 94) begin
      // print or other syscall code
      offer_instr(itype(OP_ADDI, 5'd0, 5'd2, ($urandom_range(0, 1)) ? 16'd1 : 16'd7));
      w = rtype(FN_SYS, 5'($urandom()), 5'($urandom()), 5'($urandom()), 5'($urandom()));
    end
    offer_instr(keep_v0(w));
  endtask

  initial begin
    logic [4:0] rr;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every data word with random content.
    for (int i = 0; i < DATA_WORDS_DEF; i++) begin
      rr = 5'($urandom_range(3, 31));
      offer_instr(itype(OP_ORI, 5'd0, rr, 16'($urandom())));
      offer_instr(itype(OP_SW, 5'd0, rr, 16'(i)));
    end

    // Directed corners.
    offer_instr(itype(OP_ADDI, 5'd0, 5'd1, 16'hFFFF));
    offer_instr(itype(OP_ORI, 5'd0, 5'd3, 16'hFFFF));
    offer_instr(rtype(FN_SLL, 5'd0, 5'd1, 5'd5, 5'd31));
    offer_instr(rtype(FN_ADD, 5'd1, 5'd5, 5'd6, 5'd0));
    offer_instr(rtype(FN_SUB, 5'd5, 5'd1, 5'd6, 5'd0));
    offer_instr(rtype(FN_MULT, 5'd1, 5'd1, 5'd6, 5'd0));
    offer_instr(rtype(FN_DIV, 5'd1, 5'd0, 5'd7, 5'd0));
    offer_instr(rtype(FN_DIV, 5'd1, 5'd3, 5'd7, 5'd0));
    offer_instr(rtype(FN_NOR, 5'd5, 5'd3, 5'd8, 5'd0));
    offer_instr(rtype(FN_SLT, 5'd5, 5'd3, 5'd9, 5'd0));
    offer_instr(rtype(FN_SRA, 5'd0, 5'd5, 5'd10, 5'd31));
    offer_instr(rtype(FN_SRL, 5'd0, 5'd5, 5'd11, 5'd31));
    offer_instr(rtype(FN_ADD, 5'd1, 5'd1, 5'd0, 5'd0));
    offer_instr(itype(OP_SLTI, 5'd1, 5'd12, 16'h8000));
    offer_instr(itype(OP_LW, 5'd0, 5'd13, 16'd255));
    offer_instr(itype(OP_LW, 5'd0, 5'd13, 16'd256));
    offer_instr(itype(OP_SW, 5'd0, 5'd1, 16'h8000));
    offer_instr(itype(OP_BEQ, 5'd0, 5'd0, 16'hFFFF));
    offer_instr(itype(OP_BNE, 5'd1, 5'd0, 16'h7FFF));
    offer_instr(itype(OP_BGTZ, 5'd1, 5'd0, 16'h0010));
    offer_instr({OP_JAL, 26'h3FF_FFFF});
    offer_instr(rtype(FN_JR, 5'd1, 5'd0, 5'd0, 5'd0));
    offer_instr({6'h3F, 26'h0});
    offer_instr(rtype(6'h3F, 5'd1, 5'd1, 5'd4, 5'd0));
    offer_instr(itype(OP_ADDI, 5'd0, 5'd2, 16'd1));
    offer_instr(rtype(FN_SYS, 5'd0, 5'd0, 5'd0, 5'd0));

    for (int n = 0; n < 800; n++) begin
      if (n == 200) no_idle = 1'b1;
      if (n == 300) no_idle = 1'b0;
      if (n == 400) hold_req = 1'b1;
      if (n == 550) drain_all();
      random_instr();
    end

    // Halt, then show that further requests leave the state unchanged and report halt.
    offer_instr(itype(OP_ADDI, 5'd0, 5'd2, 16'd10));
    offer_instr(rtype(FN_SYS, 5'd0, 5'd0, 5'd0, 5'd0));
    for (int n = 0; n < 5; n++) offer_instr($urandom());
    drain_all();
    repeat (50) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
